/* hdl/ake_pkg.sv */
// ----------------------------------------------------------------------------
// ake_pkg
// Shared types and constants for the AES key expansion block.
// ----------------------------------------------------------------------------
package ake_pkg;

    localparam int unsigned MaxWords  = 60;
    localparam int unsigned WinWords  = 8;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [31:0] word_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture key into window
        logic       step;      // emit one word, advance window
        logic       key_phase; // emitted word comes from the key itself
        logic       rot_sub;   // RotWord + SubWord + Rcon
        logic       sub_only;  // SubWord only
    } ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* hdl/ake_datapath.sv */
// ----------------------------------------------------------------------------
// ake_datapath
// Eight-word window holding the last Nk schedule words, shared SubWord unit and Rcon.
// ----------------------------------------------------------------------------
module ake_datapath
(
    input  logic                clk,
    input  ake_pkg::ctrl_t      ctrl,
    input  logic [1:0]          mode,
    input  logic [255:0]        key,
    output ake_pkg::word_t      word
);

    // win_reg[0] is the next word to emit during the key phase,
    // and w[i-Nk] otherwise; win_reg[nk-1] is w[i-1].
    ake_pkg::word_t win_reg [ake_pkg::WinWords];
    ake_pkg::word_t win_next [ake_pkg::WinWords];
    logic [7:0]     rcon_reg;
    logic [7:0]     rcon_next;
    ake_pkg::word_t prev;
    ake_pkg::word_t sub_in;
    ake_pkg::word_t sub_out;
    ake_pkg::word_t t;
    ake_pkg::word_t new_word;

    always_comb
    begin
        unique case (mode)
            ake_pkg::MODE_128: prev = win_reg[3];
            ake_pkg::MODE_192: prev = win_reg[5];
            default:           prev = win_reg[7];
        endcase
    end

    assign sub_in  = ctrl.rot_sub ? {prev[23:0], prev[31:24]} : prev;
    assign sub_out = {ake_pkg::sbox(sub_in[31:24]), ake_pkg::sbox(sub_in[23:16]),
                      ake_pkg::sbox(sub_in[15:8]),  ake_pkg::sbox(sub_in[7:0])};

    always_comb
    begin
        priority if (ctrl.rot_sub)
            t = sub_out ^ {rcon_reg, 24'h0};
        else if (ctrl.sub_only)
            t = sub_out;
        else
            t = prev;
    end

    assign new_word = win_reg[0] ^ t;
    assign word     = ctrl.key_phase ? win_reg[0] : new_word;

    always_comb
    begin
        win_next  = win_reg;
        rcon_next = rcon_reg;
        if (ctrl.load)
        begin
            for (int k = 0; k < ake_pkg::WinWords; k++)
                win_next[k] = key[255 - 32*k -: 32];
            rcon_next = ake_pkg::RCON_INIT;
        end
        else if (ctrl.step)
        begin
            if (ctrl.key_phase)
            begin
                // rotate so key words stay in order, with the key back in place
                for (int k = 0; k < ake_pkg::WinWords - 1; k++)
                    win_next[k] = win_reg[k+1];
                unique case (mode)
                    ake_pkg::MODE_128:
                    begin
                        win_next[3] = win_reg[0];
                        win_next[4] = win_reg[5];
                    end
                    ake_pkg::MODE_192:
                    begin
                        win_next[5] = win_reg[0];
                        win_next[6] = win_reg[7];
                    end
                    default: win_next[7] = win_reg[0];
                endcase
            end
            else
            begin
                for (int k = 0; k < ake_pkg::WinWords - 1; k++)
                    win_next[k] = win_reg[k+1];
                unique case (mode)
                    ake_pkg::MODE_128: win_next[3] = new_word;
                    ake_pkg::MODE_192: win_next[5] = new_word;
                    default:           win_next[7] = new_word;
                endcase
            end
            if (ctrl.rot_sub)
                rcon_next = ake_pkg::xtime(rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        rcon_reg <= rcon_next;
    end

endmodule

/* hdl/ake_ctrl.sv */
// ----------------------------------------------------------------------------
// ake_ctrl
// Sequencer: word counter, position within the key period, phase flags.
// ----------------------------------------------------------------------------
module ake_ctrl
#(
    parameter int unsigned TOTAL = 60
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     mode,
    output logic           busy,
    output ake_pkg::ctrl_t ctrl,
    output logic [5:0]     idx,
    output logic           last
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0] state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic [2:0] pos_reg, pos_next;   // idx mod nk
    logic [2:0] nk_m1;

    always_comb
    begin
        unique case (mode)
            ake_pkg::MODE_128: nk_m1 = 3'd3;
            ake_pkg::MODE_192: nk_m1 = 3'd5;
            default:           nk_m1 = 3'd7;
        endcase
    end

    assign busy = (state_reg == ST_RUN);
    assign idx  = idx_reg;
    assign last = busy && (idx_reg == 6'(TOTAL - 1));

    always_comb
    begin
        ctrl.load      = !busy && start;
        ctrl.step      = busy;
        ctrl.key_phase = (idx_reg <= {3'd0, nk_m1});
        ctrl.rot_sub   = !ctrl.key_phase && (pos_reg == 3'd0);
        ctrl.sub_only  = !ctrl.key_phase && (nk_m1 == 3'd7) && (pos_reg == 3'd4);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                    pos_next   = '0;
                end
            default:
            begin
                idx_next = idx_reg + 6'd1;
                pos_next = (pos_reg == nk_m1) ? 3'd0 : pos_reg + 3'd1;
                if (last)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* hdl/aes_key_expansion.sv */
// ----------------------------------------------------------------------------
// aes_key_expansion
// AES-128/192/256 key schedule, one 32-bit word emitted per clock.
// ----------------------------------------------------------------------------
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+------------------------
//  key in   | start, busy, key_part0..3             | start && !busy
//  words out| word_valid, round_key_word, word_index, last_word | word_valid
//  config   | psel, penable, pwrite, paddr, pwdata  | psel&penable&pwrite
//
// For each key the eight-word window is loaded first, then one word per cycle
// is emitted, with a single shared SubWord unit. The next key can be
// taken the cycle after last_word. Reset clears the sequencer and sets the
// key size to 128 bits. The receiver cannot stall; words are never held.
// ----------------------------------------------------------------------------
module aes_key_expansion
#(
    parameter int unsigned SCHEDULE_WORDS = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] key_part0,
    input  logic [63:0] key_part1,
    input  logic [63:0] key_part2,
    input  logic [63:0] key_part3,
    output logic        word_valid,
    output logic [31:0] round_key_word,
    output logic [5:0]  word_index,
    output logic        last_word
);

    // clamp like the schedule length rule: never beyond the full 60 words
    localparam int unsigned Total =
        (SCHEDULE_WORDS > ake_pkg::MaxWords) ? ake_pkg::MaxWords : SCHEDULE_WORDS;

    logic [1:0]     mode_reg;
    logic [1:0]     mode_eff;
    ake_pkg::ctrl_t ctrl;
    logic [5:0]     idx;
    logic           last;
    ake_pkg::word_t word;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, mode_reg} : 32'd0;

    // mode 3 means nothing: treat as a 256-bit key
    assign mode_eff = (mode_reg == 2'd3) ? ake_pkg::MODE_256 : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ake_pkg::MODE_128;
        else if (psel && penable && pwrite && paddr == 2'd0)
            mode_reg <= pwdata[1:0];
    end

    ake_ctrl #(.TOTAL(Total)) u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode_eff),
        .busy  (busy),
        .ctrl  (ctrl),
        .idx   (idx),
        .last  (last)
    );

    ake_datapath u_dp
    (
        .clk  (clk),
        .ctrl (ctrl),
        .mode (mode_eff),
        .key  ({key_part0, key_part1, key_part2, key_part3}),
        .word (word)
    );

    // words go straight out in the cycle they are formed
    assign word_valid     = busy;
    assign round_key_word = word;
    assign word_index     = idx;
    assign last_word      = last;

endmodule

/* hdl/ake_checker.sv */
// ----------------------------------------------------------------------------
// ake_checker
// Port-level checks on the key schedule stream.
// ----------------------------------------------------------------------------
module ake_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       word_valid,
    input logic [5:0] word_index,
    input logic       last_word
);

    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (word_valid && word_index == 6'd0))
        else $error("schedule does not open at word 0");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !last_word) |=> (word_valid && word_index == $past(word_index) + 6'd1))
        else $error("word index skipped");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && last_word) |=> !word_valid)
        else $error("words after last");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_word |-> word_valid)
        else $error("last without word");

endmodule

bind aes_key_expansion ake_checker u_ake_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .word_valid (word_valid),
    .word_index (word_index),
    .last_word  (last_word)
);
